### rtl/core/chlbf_pkg.sv
// ----------------------------------------------------------------------------
// chlbf_pkg
// Shared types and constants for the column histogram lane base finder:
// transaction payloads, queue entry, back-end status and state encoding.
// ----------------------------------------------------------------------------
package chlbf_pkg;

	// Default column capacity of the histogram memory
	localparam int MAX_COLS_DEF = 2048;

	// Fixed field widths
	localparam int COUNT_W = 12;
	localparam int WIDTH_W = 12;
	localparam int COL_W   = 11;

	// Largest column count an 11-bit position can address
	localparam int COL_LIMIT = 2048;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd1280;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input transaction
	typedef struct packed {
		logic pixel_set;
		logic last_in_frame;
	} pix_t;

	// Result transaction
	typedef struct packed {
		logic [COL_W-1:0] left_peak;
		logic [COL_W-1:0] right_peak;
	} res_t;

	// Classified pixel handed from front to back
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             pixel_set;
		logic             last_in_frame;
	} q_entry_t;

	// Back-end status seen by the front and the top level
	typedef struct packed {
		logic clearing;
		logic scanning;
	} back_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} back_state_t;

endpackage

### rtl/core/chlbf_front.sv
// ----------------------------------------------------------------------------
// chlbf_front
// Accepts pixel transactions, holds the frame width register, tracks the
// column position and pushes each pixel with its column into the queue.
// ----------------------------------------------------------------------------
module chlbf_front import chlbf_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WIDTH_W-1:0] cfg_data,
	// pixel channel
	input  logic               pix_valid,
	output logic               pix_stall,
	input  pix_t               pix,
	// back-end status
	input  back_status_t       back_st,
	// queue push side
	input  logic               q_full,
	output logic               q_push,
	output q_entry_t           q_data,
	// effective width for the scan
	output logic [WIDTH_W-1:0] width
);

	localparam int COL_CAP = (MAX_COLS < COL_LIMIT) ? MAX_COLS : COL_LIMIT;

	logic [WIDTH_W-1:0] frame_width_q;
	logic [COL_W-1:0]   col_q;
	logic [COL_W-1:0]   col;
	logic [WIDTH_W-1:0] col_inc;

	// Clamp the programmed width to 1 .. capacity
	always_comb begin
		if (frame_width_q == '0) begin
			width = WIDTH_W'(1);
		end else if (frame_width_q > WIDTH_W'(COL_CAP)) begin
			width = WIDTH_W'(COL_CAP);
		end else begin
			width = frame_width_q;
		end
	end

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_width_q <= cfg_data;
		end
	end

	// Hold off while the queue is full or the histogram is being cleared
	assign pix_stall = q_full || back_st.clearing;
	assign q_push    = pix_valid && !pix_stall;

	// Fold an out-of-range position back to column 0
	assign col     = ({1'b0, col_q} >= width) ? '0 : col_q;
	assign col_inc = {1'b0, col} + WIDTH_W'(1);

	assign q_data.col           = col;
	assign q_data.pixel_set     = pix.pixel_set;
	assign q_data.last_in_frame = pix.last_in_frame;

	// Advance the column position, wrap at row end, restart after the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (q_push) begin
			if (pix.last_in_frame || (col_inc >= width)) begin
				col_q <= '0;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

endmodule

### rtl/core/chlbf_queue.sv
// ----------------------------------------------------------------------------
// chlbf_queue
// Short FIFO of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
module chlbf_queue import chlbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t pop_data,
	output logic     empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full     = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

### rtl/core/chlbf_back.sv
// ----------------------------------------------------------------------------
// chlbf_back
// Column count memory with a read-modify-write pipe, the end-of-frame
// scan that finds both bases while zeroing the memory, and the result
// register.
// ----------------------------------------------------------------------------
module chlbf_back import chlbf_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WIDTH_W-1:0] width,
	// queue pop side
	input  logic               q_empty,
	input  q_entry_t           q_data,
	output logic               q_pop,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res,
	// status
	output back_status_t       back_st
);

	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int CMP_W  = (ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W;
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_COLS - 1);

	back_state_t state_q;
	back_state_t state_d;

	// count memory
	logic [COUNT_W-1:0] mem [MAX_COLS];
	logic [COUNT_W-1:0] rd_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COUNT_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;

	// sweep address for clearing and scanning
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic               sweep_end;

	// update pipe
	logic               valid_s1;
	logic [ADDR_W-1:0]  col_s1;
	logic               inc_s1;
	logic               last_s1;
	logic               wvalid_q;
	logic [ADDR_W-1:0]  wcol_q;
	logic [COUNT_W-1:0] wdata_q;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] upd;

	// scan pipe
	logic               sv_s1;
	logic [ADDR_W-1:0]  sidx_s1;
	logic [COL_W-1:0]   mid;
	logic [CMP_W-1:0]   idx_c;
	logic [COUNT_W-1:0] left_max_q;
	logic [COL_W-1:0]   left_idx_q;
	logic [COUNT_W-1:0] right_max_q;
	logic [COL_W-1:0]   right_idx_q;

	logic               start_scan;
	logic               res_load;
	logic               res_valid_q;
	res_t               res_q;

	assign sweep_end  = (sweep_addr_q == ADDR_LAST);
	assign start_scan = (state_q == ST_RUN) && valid_s1 && last_s1;
	assign mid        = COL_W'(width >> 1);

	// Forward the count written on the previous edge to a repeated column
	assign base = (wvalid_q && (wcol_q == col_s1)) ? wdata_q : rd_q;
	assign upd  = (inc_s1 && (base != COUNT_MAX)) ? base + COUNT_W'(1) : base;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_end) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (start_scan) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sweep_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || !res_stall) state_d = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State outputs: memory port, queue pop, result load
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = '0;
		mem_raddr = ADDR_W'(q_data.col);
		res_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_RUN: begin
				q_pop     = !q_empty && !(valid_s1 && last_s1);
				mem_we    = valid_s1;
				mem_waddr = col_s1;
				mem_wdata = upd;
			end
			ST_SCAN: begin
				mem_we    = 1'b1;
				mem_raddr = sweep_addr_q;
			end
			ST_DRAIN: begin
				mem_we = 1'b0;
			end
			ST_DONE: begin
				res_load = !res_valid_q || !res_stall;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign back_st.clearing = (state_q == ST_CLEAR);
	assign back_st.scanning = (state_q == ST_SCAN) || (state_q == ST_DRAIN);

	// Count memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// State, sweep address and pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_addr_q <= '0;
			valid_s1     <= 1'b0;
			wvalid_q     <= 1'b0;
			sv_s1        <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= q_pop;
			wvalid_q <= (state_q == ST_RUN) && valid_s1;
			sv_s1    <= (state_q == ST_SCAN);
			if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
				sweep_addr_q <= sweep_end ? '0 : sweep_addr_q + ADDR_W'(1);
			end
		end
	end

	// Update pipe payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1  <= ADDR_W'(q_data.col);
			inc_s1  <= q_data.pixel_set;
			last_s1 <= q_data.last_in_frame;
		end
		wcol_q  <= col_s1;
		wdata_q <= upd;
		sidx_s1 <= sweep_addr_q;
	end

	assign idx_c = CMP_W'(sidx_s1);

	// Track the first maximum of each half during the scan
	always_ff @(posedge clk) begin
		if (start_scan) begin
			left_max_q  <= '0;
			left_idx_q  <= '0;
			right_max_q <= '0;
			right_idx_q <= mid;
		end else if (sv_s1) begin
			if (idx_c < CMP_W'(mid)) begin
				if (rd_q > left_max_q) begin
					left_max_q <= rd_q;
					left_idx_q <= COL_W'(sidx_s1);
				end
			end else if (idx_c < CMP_W'(width)) begin
				if (rd_q > right_max_q) begin
					right_max_q <= rd_q;
					right_idx_q <= COL_W'(sidx_s1);
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.left_peak  <= left_idx_q;
			res_q.right_peak <= right_idx_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/column_histogram_lane_base_finder.sv
// Pixels are taken at one per cycle while the queue has room and no clearing pass runs;
// a result follows the frame's last pixel once the scan has swept the count memory one
// entry per cycle (read and zero in the same pass) and passed the drain and done states.
// During that sweep the four-entry queue fills and pixel input stalls until the back
// end resumes. After reset a clearing pass zeroes the count memory; pixel input stalls
// during it, configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// column_histogram_lane_base_finder
// Per-column histogram of a binary lane mask with a left/right peak search
// at the end of each frame.
// ----------------------------------------------------------------------------
module column_histogram_lane_base_finder import chlbf_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WIDTH_W-1:0] cfg_data,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  pix_t               pix,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res
);

	back_status_t       back_st;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	q_entry_t           q_wdata;
	q_entry_t           q_rdata;
	logic [WIDTH_W-1:0] width;

	// Front: accept and classify pixels
	chlbf_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.back_st   (back_st),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.width     (width)
	);

	// Queue between front and back
	chlbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Back: count, scan, report
	chlbf_back #(
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (width),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.back_st   (back_st)
	);

	// No pixel enters while the memory is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.clearing |-> pix_stall)
		else $error("pixel accepted during clearing pass");

	// Queue never overflows or underflows
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push |-> !q_full) and (q_pop |-> !q_empty))
		else $error("queue overflow or underflow");

	// The scan owns the memory port: no pixel leaves the queue
	a_no_pop_scan: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.scanning |-> !q_pop)
		else $error("queue popped during scan");

	// Left base never lies past the right base
	a_base_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.left_peak <= res.right_peak))
		else $error("left base beyond right base");

endmodule
